// ===== rtl/core/hpl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpl_pkg
// Shared widths, register indexes, reset values and command types for the
// heater PWM limiter with i2t budget.
// ----------------------------------------------------------------------------
package hpl_pkg;

    localparam int HPL_SAMPLE_COUNT = 64;

    localparam int DUTY_W     = 10;
    localparam int ENERGY_W   = 26;
    localparam int TEMP_W     = 15;
    localparam int FAC_W      = 9;
    localparam int PER_W      = 16;
    localparam int SQ_W       = 20;
    localparam int ROOT_W     = 13;
    localparam int QUO_W      = 16;
    localparam int DVD_W      = ENERGY_W + 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 26;

    localparam logic [DUTY_W-1:0] PERMILLE_FULL = 10'd1000;
    localparam logic [FAC_W-1:0]  Q08_ONE       = 9'd256;

    localparam logic [CFG_IDX_W-1:0] CFG_HARD_MAX_DUTY    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENERGY       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_THRESHOLD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DERATE_FACTOR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REDUCTION_FACTOR = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_INTERVAL  = 3'd6;

    localparam logic [DUTY_W-1:0]        RST_HARD_MAX_DUTY    = 10'd1000;
    localparam logic [ENERGY_W-1:0]      RST_MAX_ENERGY       = 26'd10000000;
    localparam logic signed [TEMP_W-1:0] RST_TEMP_THRESHOLD   = 15'sd2500;
    localparam logic [FAC_W-1:0]         RST_DERATE_FACTOR    = 9'd205;
    localparam logic [FAC_W-1:0]         RST_REDUCTION_FACTOR = 9'd128;
    localparam logic [PER_W-1:0]         RST_PWM_PERIOD       = 16'd1000;
    localparam logic [PER_W-1:0]         RST_SAMPLE_INTERVAL  = 16'd100;
    localparam logic signed [TEMP_W-1:0] RST_STORED_TEMP      = 15'sd300;

    typedef enum logic [1:0] {
        DIV_REQ = 2'd0,
        DIV_ON  = 2'd1,
        DIV_USE = 2'd2
    } div_sel_t;

    typedef struct packed {
        logic     accept;
        logic     ring_rd;
        logic     ring_wr;
        logic     budget;
        logic     cmp;
        logic     sq_step;
        logic     limit;
        logic     div_start;
        div_sel_t div_sel;
        logic     lat_applied;
        logic     lat_on;
        logic     lat_use;
        logic     use_full;
        logic     load_out;
    } hpl_cmd_t;

    typedef struct packed {
        logic sample_due;
        logic sq_done;
        logic div_busy;
        logic use_div;
        logic out_busy;
    } hpl_stat_t;

    function automatic logic [DUTY_W-1:0] sat_permille(input logic [DUTY_W-1:0] v);
        return (v > PERMILLE_FULL) ? PERMILLE_FULL : v;
    endfunction

    function automatic logic [FAC_W-1:0] sat_q08(input logic [FAC_W-1:0] v);
        return (v > Q08_ONE) ? Q08_ONE : v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/hpl_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpl_in_if / hpl_out_if
// Valid/ready channels for tick requests and limiter results.
// ----------------------------------------------------------------------------
interface hpl_in_if
    import hpl_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [DUTY_W-1:0]        desired_power;
    logic                     temp_update;
    logic signed [TEMP_W-1:0] temp_value;

    modport source (output valid, output desired_power, output temp_update,
                    output temp_value, input ready);
    modport sink   (input valid, input desired_power, input temp_update,
                    input temp_value, output ready);
endinterface

interface hpl_out_if
    import hpl_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              heater_on;
    logic [DUTY_W-1:0] applied_power;
    logic              energy_limiting;
    logic [DUTY_W-1:0] energy_use;

    modport source (output valid, output heater_on, output applied_power,
                    output energy_limiting, output energy_use, input ready);
    modport sink   (input valid, input heater_on, input applied_power,
                    input energy_limiting, input energy_use, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/hpl_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpl_div
// Restoring divider, one quotient bit per cycle. Expects the quotient to fit
// in QUO_W bits (dividend below divisor shifted left by QUO_W).
// ----------------------------------------------------------------------------
module hpl_div
    import hpl_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [DVD_W-1:0]    dividend,
    input  wire logic [ENERGY_W-1:0] divisor,
    output logic                     busy,
    output logic [QUO_W-1:0]         quotient
);
    localparam int CNT_W = $clog2(QUO_W + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [ENERGY_W-1:0] rem_reg;
    logic [ENERGY_W-1:0] dsr_reg;
    logic [QUO_W-1:0]    low_reg;
    logic [QUO_W-1:0]    quo_reg;
    logic [ENERGY_W:0]   trial;
    logic                take;

    assign trial = {rem_reg, low_reg[QUO_W-1]};
    assign take  = (trial >= {1'b0, dsr_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(QUO_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= ENERGY_W'(dividend[DVD_W-1:QUO_W]);
            low_reg <= dividend[QUO_W-1:0];
            dsr_reg <= divisor;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? ENERGY_W'(trial - {1'b0, dsr_reg}) : trial[ENERGY_W-1:0];
            low_reg <= {low_reg[QUO_W-2:0], 1'b0};
            quo_reg <= {quo_reg[QUO_W-2:0], take};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

// ===== rtl/core/hpl_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpl_ctrl
// Tick sequencer: sample update, budget, root, two or three divide steps, result load.
// ----------------------------------------------------------------------------
module hpl_ctrl
    import hpl_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire hpl_stat_t stat,
    output hpl_cmd_t       cmd
);
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_RD    = 10'b0000000010,
        S_UPD   = 10'b0000000100,
        S_BUD   = 10'b0000001000,
        S_CMP   = 10'b0000010000,
        S_SQRT  = 10'b0000100000,
        S_LIM   = 10'b0001000000,
        S_DIVGO = 10'b0010000000,
        S_DIVWT = 10'b0100000000,
        S_FIN   = 10'b1000000000
    } state_t;

    state_t   state_reg, state_next;
    div_sel_t sel_reg, sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= DIV_REQ;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb
    begin
        cmd         = '0;
        cmd.div_sel = sel_reg;
        state_next  = state_reg;
        sel_next    = sel_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                cmd.ring_rd = 1'b1;
                state_next  = stat.sample_due ? S_UPD : S_BUD;
            end
            S_UPD:
            begin
                cmd.ring_wr = 1'b1;
                state_next  = S_BUD;
            end
            S_BUD:
            begin
                cmd.budget = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.cmp    = 1'b1;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                if (stat.sq_done)
                    state_next = S_LIM;
                else
                    cmd.sq_step = 1'b1;
            end
            S_LIM:
            begin
                cmd.limit  = 1'b1;
                sel_next   = DIV_REQ;
                state_next = S_DIVGO;
            end
            S_DIVGO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIVWT;
            end
            S_DIVWT:
            begin
                if (!stat.div_busy)
                begin
                    case (sel_reg)
                        DIV_REQ:
                        begin
                            cmd.lat_applied = 1'b1;
                            sel_next        = DIV_ON;
                            state_next      = S_DIVGO;
                        end
                        DIV_ON:
                        begin
                            cmd.lat_on = 1'b1;
                            if (stat.use_div)
                            begin
                                sel_next   = DIV_USE;
                                state_next = S_DIVGO;
                            end
                            else
                            begin
                                cmd.use_full = 1'b1;
                                state_next   = S_FIN;
                            end
                        end
                        default:
                        begin
                            cmd.lat_use = 1'b1;
                            state_next  = S_FIN;
                        end
                    endcase
                end
            end
            S_FIN:
            begin
                if (!stat.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);
endmodule
`default_nettype wire

// ===== rtl/core/hpl_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpl_datapath
// Configuration registers, sample ring, i2t sum, root unit, reciprocal scaling,
// usage divider operands and the result register.
// ----------------------------------------------------------------------------
module hpl_datapath
    import hpl_pkg::*;
#(
    parameter int SAMPLE_COUNT = HPL_SAMPLE_COUNT
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic [DUTY_W-1:0]        desired_power,
    input  wire logic                     temp_update,
    input  wire logic signed [TEMP_W-1:0] temp_value,
    input  wire logic                     out_ready,
    output logic                          out_valid,
    output logic                          heater_on,
    output logic [DUTY_W-1:0]             applied_power,
    output logic                          energy_limiting,
    output logic [DUTY_W-1:0]             energy_use,
    input  wire hpl_cmd_t                 cmd,
    output hpl_stat_t                     stat
);
    localparam int IDX_W = $clog2(SAMPLE_COUNT);
    localparam int SUM_W = $clog2(SAMPLE_COUNT * 1000000 + 1);
    localparam int CW    = ((SUM_W > ENERGY_W) ? SUM_W : ENERGY_W) + 4;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLE_COUNT - 1);
    localparam logic [ENERGY_W-1:0] ROOT_BIT0 = ENERGY_W'(1) << (ENERGY_W - 2);
    // floor(x / 1000) = (x * RECIP_1000) >> RECIP_SHIFT for any x below 2^32
    localparam int          RECIP_SHIFT = 38;
    localparam logic [28:0] RECIP_1000  = 29'd274877907;
    localparam int          PROD_W      = ENERGY_W + 29;

    // configuration
    logic [DUTY_W-1:0]        duty_reg;
    logic [ENERGY_W-1:0]      maxe_reg;
    logic signed [TEMP_W-1:0] thr_reg;
    logic [FAC_W-1:0]         dfac_reg;
    logic [FAC_W-1:0]         rfac_reg;
    logic [PER_W-1:0]         period_reg;
    logic [PER_W-1:0]         interval_reg;

    // tick state
    logic [IDX_W-1:0]         idx_reg;
    logic                     wrapped_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic [PER_W-1:0]         timer_reg;
    logic [PER_W-1:0]         window_reg;
    logic [DUTY_W-1:0]        last_reg;
    logic signed [TEMP_W-1:0] temp_reg;
    logic                     known_reg;
    logic                     due_reg;

    // per-tick working values
    logic [DUTY_W-1:0]   desired_reg;
    logic [SQ_W-1:0]     sq_reg;
    logic [SQ_W-1:0]     rd_reg;
    logic [ENERGY_W-1:0] budget_reg;
    logic                lt80_reg, gt80_reg, gt90_reg, ge_reg;
    logic [ENERGY_W-1:0] x_reg, res_reg, bit_reg;
    logic [DUTY_W-1:0]   limit_reg;
    logic [DUTY_W-1:0]   applied_reg;
    logic [QUO_W-1:0]    on_reg;
    logic [DUTY_W-1:0]   use_reg;
    logic [ENERGY_W-1:0] num_reg;

    // result register
    logic                out_valid_reg;
    logic                heater_reg;
    logic [DUTY_W-1:0]   out_applied_reg;
    logic                out_limit_reg;
    logic [DUTY_W-1:0]   out_use_reg;

    logic [SQ_W-1:0] ring_mem [SAMPLE_COUNT];

    logic [PER_W:0]      timer_inc, window_inc;
    logic                due_now;
    logic [CW-1:0]       sum_x, bud_x, sum10, bud8, bud9;
    logic [ENERGY_W:0]   rb;
    logic [21:0]         reduced;
    logic [ROOT_W:0]     lim_pre;
    logic [2*FAC_W+ENERGY_W-1:0] derated;
    logic [DVD_W-1:0]    dvd;
    logic [ENERGY_W-1:0] dsr;
    logic                div_busy;
    logic                div_go;
    logic [QUO_W-1:0]    div_quo;
    logic [PROD_W-1:0]   recip_prod;
    logic [QUO_W-1:0]    recip_quo;
    logic [QUO_W-1:0]    quo;

    assign timer_inc  = {1'b0, timer_reg} + 1'b1;
    assign window_inc = {1'b0, window_reg} + 1'b1;
    assign due_now    = (timer_inc >= {1'b0, interval_reg});

    assign sum_x = CW'(sum_reg);
    assign bud_x = CW'(budget_reg);
    assign sum10 = (sum_x << 3) + (sum_x << 1);
    assign bud8  = bud_x << 3;
    assign bud9  = (bud_x << 3) + bud_x;

    assign rb      = {1'b0, res_reg} + {1'b0, bit_reg};
    assign reduced = 22'(res_reg[ROOT_W-1:0]) * 22'(sat_q08(rfac_reg));
    assign lim_pre = gt90_reg ? reduced[ROOT_W+8:8] : {1'b0, res_reg[ROOT_W-1:0]};
    assign derated = (2*FAC_W+ENERGY_W)'(maxe_reg) * (2*FAC_W+ENERGY_W)'(sat_q08(dfac_reg));

    // request and on-time scale by 1/1000 through the reciprocal; only the
    // usage ratio runs on the divider
    assign recip_prod = PROD_W'(num_reg) * PROD_W'(RECIP_1000);
    assign recip_quo  = recip_prod[RECIP_SHIFT+QUO_W-1:RECIP_SHIFT];
    assign div_go     = cmd.div_start && (cmd.div_sel == DIV_USE);
    assign quo        = (cmd.div_sel == DIV_USE) ? div_quo : recip_quo;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_reg     <= RST_HARD_MAX_DUTY;
            maxe_reg     <= RST_MAX_ENERGY;
            thr_reg      <= RST_TEMP_THRESHOLD;
            dfac_reg     <= RST_DERATE_FACTOR;
            rfac_reg     <= RST_REDUCTION_FACTOR;
            period_reg   <= RST_PWM_PERIOD;
            interval_reg <= RST_SAMPLE_INTERVAL;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HARD_MAX_DUTY:    duty_reg     <= cfg_wdata[DUTY_W-1:0];
                CFG_MAX_ENERGY:       maxe_reg     <= cfg_wdata[ENERGY_W-1:0];
                CFG_TEMP_THRESHOLD:   thr_reg      <= cfg_wdata[TEMP_W-1:0];
                CFG_DERATE_FACTOR:    dfac_reg     <= cfg_wdata[FAC_W-1:0];
                CFG_REDUCTION_FACTOR: rfac_reg     <= cfg_wdata[FAC_W-1:0];
                CFG_PWM_PERIOD:       period_reg   <= cfg_wdata[PER_W-1:0];
                CFG_SAMPLE_INTERVAL:  interval_reg <= cfg_wdata[PER_W-1:0];
                default: ;
            endcase
        end
    end

    // state carried from tick to tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            wrapped_reg   <= 1'b0;
            sum_reg       <= '0;
            timer_reg     <= '0;
            window_reg    <= '0;
            last_reg      <= '0;
            temp_reg      <= RST_STORED_TEMP;
            known_reg     <= 1'b0;
            due_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                if (temp_update)
                begin
                    temp_reg  <= temp_value;
                    known_reg <= 1'b1;
                end
                due_reg    <= due_now;
                timer_reg  <= due_now ? '0 : timer_inc[PER_W-1:0];
                window_reg <= (window_inc >= {1'b0, period_reg}) ? '0 : window_inc[PER_W-1:0];
            end
            if (cmd.ring_wr)
            begin
                // slots not yet written in the first lap count as zero
                sum_reg     <= sum_reg - SUM_W'(wrapped_reg ? rd_reg : '0) + SUM_W'(sq_reg);
                idx_reg     <= (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
                wrapped_reg <= wrapped_reg | (idx_reg == LAST_IDX);
            end
            if (cmd.lat_applied)
                last_reg <= (quo < QUO_W'(limit_reg)) ? quo[DUTY_W-1:0] : limit_reg;
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // sample ring
    always_ff @(posedge clk)
    begin
        if (cmd.ring_rd)
            rd_reg <= ring_mem[idx_reg];
        if (cmd.ring_wr)
            ring_mem[idx_reg] <= sq_reg;
    end

    // per-tick datapath
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            desired_reg <= sat_permille(desired_power);
            sq_reg      <= SQ_W'(last_reg) * SQ_W'(last_reg);
        end
        if (cmd.budget)
        begin
            if (known_reg && (temp_reg > thr_reg))
                budget_reg <= derated[ENERGY_W+7:8];
            else
                budget_reg <= maxe_reg;
        end
        if (cmd.cmp)
        begin
            lt80_reg <= (sum10 < bud8);
            gt80_reg <= (sum10 > bud8);
            gt90_reg <= (sum10 > bud9);
            ge_reg   <= (sum_x >= bud_x);
            x_reg    <= ENERGY_W'(bud_x - sum_x);
            res_reg  <= '0;
            bit_reg  <= ROOT_BIT0;
        end
        if (cmd.sq_step)
        begin
            if ({1'b0, x_reg} >= rb)
            begin
                x_reg   <= x_reg - rb[ENERGY_W-1:0];
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
                res_reg <= res_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.limit)
        begin
            if (lt80_reg)
                limit_reg <= PERMILLE_FULL;
            else if (ge_reg)
                limit_reg <= '0;
            else if (lim_pre > (ROOT_W+1)'(PERMILLE_FULL))
                limit_reg <= PERMILLE_FULL;
            else
                limit_reg <= lim_pre[DUTY_W-1:0];
        end
        if (cmd.div_start)
            num_reg <= dvd[ENERGY_W-1:0];
        if (cmd.lat_applied)
            applied_reg <= (quo < QUO_W'(limit_reg)) ? quo[DUTY_W-1:0] : limit_reg;
        if (cmd.lat_on)
            on_reg <= quo;
        if (cmd.lat_use)
            use_reg <= quo[DUTY_W-1:0];
        else if (cmd.use_full)
            use_reg <= PERMILLE_FULL;
        if (cmd.load_out)
        begin
            heater_reg      <= (window_reg < on_reg);
            out_applied_reg <= applied_reg;
            out_limit_reg   <= gt80_reg;
            out_use_reg     <= use_reg;
        end
    end

    // divider operands
    always_comb
    begin
        case (cmd.div_sel)
            DIV_REQ:
            begin
                dvd = DVD_W'(desired_reg) * DVD_W'(sat_permille(duty_reg));
                dsr = ENERGY_W'(PERMILLE_FULL);
            end
            DIV_ON:
            begin
                dvd = DVD_W'(period_reg) * DVD_W'(applied_reg);
                dsr = ENERGY_W'(PERMILLE_FULL);
            end
            default:
            begin
                dvd = DVD_W'(sum_x) * DVD_W'(PERMILLE_FULL);
                dsr = budget_reg;
            end
        endcase
    end

    hpl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go),
        .dividend (dvd),
        .divisor  (dsr),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    assign stat.sample_due = due_reg;
    assign stat.sq_done    = (bit_reg == '0);
    assign stat.div_busy   = div_busy;
    assign stat.use_div    = (budget_reg != '0) && !ge_reg;
    assign stat.out_busy   = out_valid_reg && !out_ready;

    assign out_valid       = out_valid_reg;
    assign heater_on       = heater_reg;
    assign applied_power   = out_applied_reg;
    assign energy_limiting = out_limit_reg;
    assign energy_use      = out_use_reg;
endmodule
`default_nettype wire

// ===== rtl/core/heater_pwm_i2t_limiter_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Tick sequence: runs the 13-step root unit, a sample update when one is
//   due and the usage divide when it runs; waits while the output is full.
// Requests: one tick at a time; the next request is taken once the result is
//   in the output register, even if it has not been taken yet.
// Reset: asynchronous, active low; config and tick state return to defaults,
//   the sample ring counts as zero until its first lap is written.
// ----------------------------------------------------------------------------
// heater_pwm_i2t_limiter_unit
// Time-proportioned heater drive with an i2t energy budget.
// ----------------------------------------------------------------------------
module heater_pwm_i2t_limiter_unit
    import hpl_pkg::*;
#(
    parameter int SAMPLE_COUNT = HPL_SAMPLE_COUNT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    hpl_in_if.sink                     in_ch,
    hpl_out_if.source                  out_ch,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);
    // Controller sequences each tick: read the ring slot, fold the new square
    // into the running sum when a sample is due, derive the budget, compare
    // against the 80 and 90 percent marks, run the root, scale request and
    // on-time by the reciprocal of 1000, divide for usage when the budget is
    // not spent, and finally drop the result into the output register.
    hpl_cmd_t  cmd;
    hpl_stat_t stat;

    hpl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath holds configuration, tick state and the result register.
    hpl_datapath #(
        .SAMPLE_COUNT (SAMPLE_COUNT)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .desired_power   (in_ch.desired_power),
        .temp_update     (in_ch.temp_update),
        .temp_value      (in_ch.temp_value),
        .out_ready       (out_ch.ready),
        .out_valid       (out_ch.valid),
        .heater_on       (out_ch.heater_on),
        .applied_power   (out_ch.applied_power),
        .energy_limiting (out_ch.energy_limiting),
        .energy_use      (out_ch.energy_use),
        .cmd             (cmd),
        .stat            (stat)
    );
endmodule
`default_nettype wire

// ===== rtl/core/hpl_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpl_checker
// Port-level checks on the limiter, bound to the top level.
// ----------------------------------------------------------------------------
module hpl_checker
    import hpl_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic              heater_on,
    input wire logic [DUTY_W-1:0] applied_power,
    input wire logic [DUTY_W-1:0] energy_use
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before it was taken");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while a tick is in progress");

    a_applied_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (applied_power <= PERMILLE_FULL))
        else $error("applied power above full scale");

    a_use_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (energy_use <= PERMILLE_FULL))
        else $error("energy use above full scale");

    a_off_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (applied_power == '0) |-> !heater_on)
        else $error("heater on with zero applied power");
endmodule

bind heater_pwm_i2t_limiter_unit hpl_checker u_hpl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .heater_on     (out_ch.heater_on),
    .applied_power (out_ch.applied_power),
    .energy_use    (out_ch.energy_use)
);
`default_nettype wire
